// ===== hw/rtl/chgs_pkg.sv =====
// Shared types, constants and control codes for the convex hull unit.
`timescale 1ns / 1ps
`default_nettype none
package chgs_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int NEAR_W     = DIFF_W + 1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_SORT_I,
        ST_SORT_KEY,
        ST_SORT_J,
        ST_SORT_B,
        ST_SORT_M1,
        ST_SORT_M2,
        ST_SORT_DEC,
        ST_SCAN_START,
        ST_SCAN_INIT1,
        ST_SCAN_I,
        ST_SCAN_B,
        ST_SCAN_CHK,
        ST_SCAN_O_ADDR,
        ST_SCAN_O,
        ST_SCAN_A_ADDR,
        ST_SCAN_A,
        ST_SCAN_M1,
        ST_SCAN_M2,
        ST_SCAN_DEC,
        ST_EMIT_RD,
        ST_EMIT_ADDR,
        ST_EMIT_OUT,
        ST_EMIT_WAIT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_RD_I,
        OP_KEY_LD,
        OP_RD_JM1,
        OP_B_SORT,
        OP_MUL1,
        OP_MUL2,
        OP_SHIFT,
        OP_PLACE,
        OP_STK0,
        OP_STK1,
        OP_B_SCAN,
        OP_STK_RD_DM2,
        OP_RD_STK,
        OP_O_LD,
        OP_A_LD,
        OP_PUSH,
        OP_POP,
        OP_EMIT_INIT,
        OP_STK_RD_K,
        OP_RD_K,
        OP_OUT_LD,
        OP_DONE
    } op_t;

    typedef struct packed {
        logic in_final;
        logic i_ge_n;
        logic j_zero;
        logic depth_ge2;
        logic small_set;
        logic k_ge_cnt;
        logic precedes;
        logic left_turn;
        logic out_valid;
    } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/chgs_datapath.sv =====
// Datapath: point store, index stack, counters, cross product unit and output register.
`timescale 1ns / 1ps
`default_nettype none
module chgs_datapath
    import chgs_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire op_t                op,
    output status_t                 status,
    input  wire logic               s_valid,
    input  wire logic signed [15:0] s_pt_x,
    input  wire logic signed [15:0] s_pt_y,
    input  wire logic               s_final_point,
    input  wire logic               m_ready,
    output logic                    m_valid,
    output logic signed [15:0]      m_hull_x,
    output logic signed [15:0]      m_hull_y,
    output logic                    m_last_vertex
);

    point_t store_mem [MAX_POINTS];
    idx_t   stk_mem   [MAX_POINTS];
    point_t st_rdata_reg;
    idx_t   stk_rdata_reg;

    cnt_t n_reg, i_reg, j_reg, depth_reg, k_reg;
    point_t piv_reg, key_reg, o_reg, a_reg, b_reg, out_reg;
    logic out_last_reg, out_valid_reg;
    logic signed [PROD_W-1:0] p1_reg, p2_reg;

    point_t in_pt;
    logic   fire, room;
    logic   st_we, st_re, stk_we, stk_re;
    idx_t   st_waddr, st_raddr, stk_waddr, stk_raddr;
    point_t st_wdata;
    idx_t   stk_wdata;
    cnt_t   emit_cnt;

    logic signed [DIFF_W-1:0]  dax, day, dbx, dby, abs_day, abs_dby, mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [CROSS_W-1:0] cross_val;
    logic signed [NEAR_W-1:0]  near_a, near_b;

    assign in_pt.x = s_pt_x[COORD_BITS-1:0];
    assign in_pt.y = s_pt_y[COORD_BITS-1:0];
    assign fire    = (op == OP_LOAD) && s_valid;
    assign room    = n_reg < cnt_t'(MAX_POINTS);

    // Store and stack port selection.
    always_comb begin
        st_we    = 1'b0;
        st_waddr = n_reg[IDX_W-1:0];
        st_wdata = in_pt;
        st_re    = 1'b1;
        st_raddr = i_reg[IDX_W-1:0];
        stk_we    = 1'b0;
        stk_waddr = depth_reg[IDX_W-1:0];
        stk_wdata = i_reg[IDX_W-1:0];
        stk_re    = 1'b1;
        stk_raddr = k_reg[IDX_W-1:0];
        unique case (op)
            OP_LOAD: begin
                st_we = fire && room;
            end
            OP_SHIFT: begin
                st_we    = 1'b1;
                st_waddr = j_reg[IDX_W-1:0];
                st_wdata = b_reg;
            end
            OP_PLACE: begin
                st_we    = 1'b1;
                st_waddr = j_reg[IDX_W-1:0];
                st_wdata = key_reg;
            end
            OP_RD_JM1: begin
                st_raddr = idx_t'(j_reg - cnt_t'(1));
            end
            OP_RD_STK: begin
                st_raddr = stk_rdata_reg;
            end
            OP_RD_K: begin
                st_raddr = k_reg[IDX_W-1:0];
            end
            OP_STK0: begin
                stk_we    = 1'b1;
                stk_waddr = idx_t'(0);
                stk_wdata = idx_t'(0);
            end
            OP_STK1: begin
                stk_we    = 1'b1;
                stk_waddr = idx_t'(1);
                stk_wdata = idx_t'(1);
            end
            OP_PUSH: begin
                stk_we = 1'b1;
            end
            OP_STK_RD_DM2: begin
                stk_raddr = idx_t'(depth_reg - cnt_t'(2));
            end
            OP_O_LD: begin
                stk_raddr = idx_t'(depth_reg - cnt_t'(1));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (st_we) begin
            store_mem[st_waddr] <= st_wdata;
        end
        if (st_re) begin
            st_rdata_reg <= store_mem[st_raddr];
        end
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            stk_rdata_reg <= stk_mem[stk_raddr];
        end
    end

    // Cross product of (a - o) and (b - o), formed from two products computed in turn.
    assign dax = DIFF_W'($signed(a_reg.x)) - DIFF_W'($signed(o_reg.x));
    assign day = DIFF_W'($signed(a_reg.y)) - DIFF_W'($signed(o_reg.y));
    assign dbx = DIFF_W'($signed(b_reg.x)) - DIFF_W'($signed(o_reg.x));
    assign dby = DIFF_W'($signed(b_reg.y)) - DIFF_W'($signed(o_reg.y));
    assign mul_a = (op == OP_MUL2) ? day : dax;
    assign mul_b = (op == OP_MUL2) ? dbx : dby;
    assign prod  = mul_a * mul_b;
    assign cross_val = CROSS_W'(p1_reg) - CROSS_W'(p2_reg);

    // Points collinear with the pivot lie on one ray from it, so dx + |dy| orders distance.
    assign abs_day = day[DIFF_W-1] ? -day : day;
    assign abs_dby = dby[DIFF_W-1] ? -dby : dby;
    assign near_a  = NEAR_W'(dax) + NEAR_W'(abs_day);
    assign near_b  = NEAR_W'(dbx) + NEAR_W'(abs_dby);

    assign emit_cnt = (n_reg < cnt_t'(3)) ? n_reg : depth_reg;

    assign status.in_final  = s_final_point;
    assign status.i_ge_n    = i_reg >= n_reg;
    assign status.j_zero    = j_reg == '0;
    assign status.depth_ge2 = depth_reg >= cnt_t'(2);
    assign status.small_set = n_reg < cnt_t'(3);
    assign status.k_ge_cnt  = k_reg >= emit_cnt;
    assign status.precedes  = (cross_val > 0) || ((cross_val == 0) && (near_a < near_b));
    assign status.left_turn = cross_val > 0;
    assign status.out_valid = out_valid_reg;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            depth_reg     <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (op)
                OP_LOAD: begin
                    if (fire && room) begin
                        n_reg <= n_reg + cnt_t'(1);
                    end
                    if (fire && s_final_point) begin
                        i_reg <= cnt_t'(1);
                    end
                end
                OP_KEY_LD: j_reg <= i_reg;
                OP_SHIFT:  j_reg <= j_reg - cnt_t'(1);
                OP_PLACE:  i_reg <= i_reg + cnt_t'(1);
                OP_STK1: begin
                    depth_reg <= cnt_t'(2);
                    i_reg     <= cnt_t'(2);
                end
                OP_PUSH: begin
                    depth_reg <= depth_reg + cnt_t'(1);
                    i_reg     <= i_reg + cnt_t'(1);
                end
                OP_POP:       depth_reg <= depth_reg - cnt_t'(1);
                OP_EMIT_INIT: k_reg <= '0;
                OP_OUT_LD: begin
                    k_reg         <= k_reg + cnt_t'(1);
                    out_valid_reg <= 1'b1;
                end
                OP_DONE: begin
                    n_reg     <= '0;
                    depth_reg <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (fire && room && ((n_reg == '0) || (in_pt.x < piv_reg.x) ||
                ((in_pt.x == piv_reg.x) && (in_pt.y < piv_reg.y)))) begin
            piv_reg <= in_pt;
        end
        unique case (op)
            OP_KEY_LD: key_reg <= st_rdata_reg;
            OP_B_SORT: begin
                b_reg <= st_rdata_reg;
                o_reg <= piv_reg;
                a_reg <= key_reg;
            end
            OP_B_SCAN: b_reg <= st_rdata_reg;
            OP_O_LD:   o_reg <= st_rdata_reg;
            OP_A_LD:   a_reg <= st_rdata_reg;
            OP_MUL1:   p1_reg <= prod;
            OP_MUL2:   p2_reg <= prod;
            OP_OUT_LD: begin
                out_reg      <= st_rdata_reg;
                out_last_reg <= (k_reg + cnt_t'(1)) == emit_cnt;
            end
            default: begin
            end
        endcase
    end

    assign m_valid       = out_valid_reg;
    assign m_hull_x      = 16'($signed(out_reg.x));
    assign m_hull_y      = 16'($signed(out_reg.y));
    assign m_last_vertex = out_last_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/chgs_controller.sv =====
// Controller: sequences load, insertion sort, Graham scan and vertex output.
`timescale 1ns / 1ps
`default_nettype none
module chgs_controller
    import chgs_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    input  wire status_t status,
    output op_t          op,
    output logic         s_ready
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid && status.in_final) state_next = ST_SORT_I;
            end
            ST_SORT_I:     state_next = status.i_ge_n ? ST_SCAN_START : ST_SORT_KEY;
            ST_SORT_KEY:   state_next = ST_SORT_J;
            ST_SORT_J:     state_next = status.j_zero ? ST_SORT_I : ST_SORT_B;
            ST_SORT_B:     state_next = ST_SORT_M1;
            ST_SORT_M1:    state_next = ST_SORT_M2;
            ST_SORT_M2:    state_next = ST_SORT_DEC;
            ST_SORT_DEC:   state_next = status.precedes ? ST_SORT_J : ST_SORT_I;
            ST_SCAN_START: state_next = status.small_set ? ST_EMIT_RD : ST_SCAN_INIT1;
            ST_SCAN_INIT1: state_next = ST_SCAN_I;
            ST_SCAN_I:     state_next = status.i_ge_n ? ST_EMIT_RD : ST_SCAN_B;
            ST_SCAN_B:     state_next = ST_SCAN_CHK;
            ST_SCAN_CHK:   state_next = status.depth_ge2 ? ST_SCAN_O_ADDR : ST_SCAN_I;
            ST_SCAN_O_ADDR: state_next = ST_SCAN_O;
            ST_SCAN_O:     state_next = ST_SCAN_A_ADDR;
            ST_SCAN_A_ADDR: state_next = ST_SCAN_A;
            ST_SCAN_A:     state_next = ST_SCAN_M1;
            ST_SCAN_M1:    state_next = ST_SCAN_M2;
            ST_SCAN_M2:    state_next = ST_SCAN_DEC;
            ST_SCAN_DEC:   state_next = status.left_turn ? ST_SCAN_I : ST_SCAN_CHK;
            ST_EMIT_RD: begin
                priority if (status.k_ge_cnt) state_next = ST_LOAD;
                else if (status.small_set)    state_next = ST_EMIT_OUT;
                else                          state_next = ST_EMIT_ADDR;
            end
            ST_EMIT_ADDR:  state_next = ST_EMIT_OUT;
            ST_EMIT_OUT:   state_next = ST_EMIT_WAIT;
            ST_EMIT_WAIT:  state_next = status.out_valid ? ST_EMIT_WAIT : ST_EMIT_RD;
            default:       state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        op      = OP_NONE;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                op      = OP_LOAD;
                s_ready = 1'b1;
            end
            ST_SORT_I:     op = status.i_ge_n ? OP_NONE : OP_RD_I;
            ST_SORT_KEY:   op = OP_KEY_LD;
            ST_SORT_J:     op = status.j_zero ? OP_PLACE : OP_RD_JM1;
            ST_SORT_B:     op = OP_B_SORT;
            ST_SORT_M1:    op = OP_MUL1;
            ST_SORT_M2:    op = OP_MUL2;
            ST_SORT_DEC:   op = status.precedes ? OP_SHIFT : OP_PLACE;
            ST_SCAN_START: op = status.small_set ? OP_EMIT_INIT : OP_STK0;
            ST_SCAN_INIT1: op = OP_STK1;
            ST_SCAN_I:     op = status.i_ge_n ? OP_EMIT_INIT : OP_RD_I;
            ST_SCAN_B:     op = OP_B_SCAN;
            ST_SCAN_CHK:   op = status.depth_ge2 ? OP_STK_RD_DM2 : OP_PUSH;
            ST_SCAN_O_ADDR: op = OP_RD_STK;
            ST_SCAN_O:     op = OP_O_LD;
            ST_SCAN_A_ADDR: op = OP_RD_STK;
            ST_SCAN_A:     op = OP_A_LD;
            ST_SCAN_M1:    op = OP_MUL1;
            ST_SCAN_M2:    op = OP_MUL2;
            ST_SCAN_DEC:   op = status.left_turn ? OP_PUSH : OP_POP;
            ST_EMIT_RD: begin
                priority if (status.k_ge_cnt) op = OP_DONE;
                else if (status.small_set)    op = OP_RD_K;
                else                          op = OP_STK_RD_K;
            end
            ST_EMIT_ADDR:  op = OP_RD_STK;
            ST_EMIT_OUT:   op = OP_OUT_LD;
            ST_EMIT_WAIT:  op = OP_NONE;
            default:       op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/convex_hull_graham_scan_unit.sv =====
// Top level of the convex hull unit: controller plus datapath.
//
// Usage: points enter on the s_ channel, one transaction per cycle while
// s_ready is high; s_final_point closes the set. Up to 64 points are kept,
// later ones are dropped, but a final flag on a dropped point still starts
// the run. s_ready then stays low until the hull has been delivered.
// The pivot is tracked while loading. An insertion sort by polar angle
// follows, then the Graham scan. Each hull vertex leaves through a single
// output register as one m_ transaction; the next vertex is read through
// the single read port of the point store only after the previous one
// has been taken. m_last_vertex marks the last one. Sets of one or two
// points come out in sorted order.
// A stalled receiver simply holds the output register; the sequencer waits.
// Synchronous reset empties the set and returns to loading; the point and
// stack memories need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module convex_hull_graham_scan_unit
    import chgs_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_pt_x,
    input  wire logic signed [15:0] s_pt_y,
    input  wire logic               s_final_point,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_hull_x,
    output logic signed [15:0]      m_hull_y,
    output logic                    m_last_vertex
);

    op_t     op;
    status_t status;

    chgs_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .status  (status),
        .op      (op),
        .s_ready (s_ready)
    );

    chgs_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .op            (op),
        .status        (status),
        .s_valid       (s_valid),
        .s_pt_x        (s_pt_x),
        .s_pt_y        (s_pt_y),
        .s_final_point (s_final_point),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_hull_x      (m_hull_x),
        .m_hull_y      (m_hull_y),
        .m_last_vertex (m_last_vertex)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/chgs_checker.sv =====
// Port-level checker for the convex hull unit and its bind.
`timescale 1ns / 1ps
`default_nettype none
module chgs_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               s_final_point,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [15:0] m_hull_x,
    input wire logic signed [15:0] m_hull_y,
    input wire logic               m_last_vertex
);

    // A held result keeps its payload until its transaction completes.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hull_x) && $stable(m_hull_y)
            && $stable(m_last_vertex))
        else $error("output changed while stalled");

    // Loading and delivering never overlap.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input open while a result is pending");

    // A final point closes the input until the hull is out.
    a_final_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_final_point |=> !s_ready)
        else $error("input still open after final point");

    // After the last vertex is taken, the input reopens for loading.
    a_reopen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_vertex |-> ##3 s_ready)
        else $error("input did not reopen after last vertex");

endmodule

bind convex_hull_graham_scan_unit chgs_checker u_chgs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_final_point (s_final_point),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_hull_x      (m_hull_x),
    .m_hull_y      (m_hull_y),
    .m_last_vertex (m_last_vertex)
);
`default_nettype wire

// ===== dv/convex_hull_graham_scan_unit_test.sv =====
// Self-checking testbench for the convex hull unit, with a scoreboard that predicts each hull.
`timescale 1ns / 1ps
module convex_hull_graham_scan_unit_test;
    import chgs_pkg::*;

    localparam int IDLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        coord_t x;
        coord_t y;
        logic   last;
    } vertex_t;

    // Holds a copy of the point set and predicts the hull vertices for each set.
    class hull_scoreboard;
        longint  px [MAX_POINTS];
        longint  py [MAX_POINTS];
        int      stk [MAX_POINTS];
        int      count;
        vertex_t hull_q [$];
        int      mismatches;
        longint  pvx, pvy;

        function new();
            count = 0;
            mismatches = 0;
        endfunction

        function longint cross3(longint ox, longint oy, longint ax, longint ay,
                                longint bx, longint by);
            return (ax - ox) * (by - oy) - (ay - oy) * (bx - ox);
        endfunction

        function bit angle_before(longint ax, longint ay, longint bx, longint by);
            longint c;
            c = cross3(pvx, pvy, ax, ay, bx, by);
            if (c == 0)
                return ((ax - pvx) * (ax - pvx) + (ay - pvy) * (ay - pvy)) <
                       ((bx - pvx) * (bx - pvx) + (by - pvy) * (by - pvy));
            return c > 0;
        endfunction

        function void push_vertex(int i, bit last);
            vertex_t v;
            v.x = coord_t'(px[i]);
            v.y = coord_t'(py[i]);
            v.last = last;
            hull_q.insert(hull_q.size(), v);
        endfunction

        // Notes one accepted input transaction; a final point runs the hull prediction.
        function void note_point(coord_t x, coord_t y, logic fin);
            int n, i, j, depth;
            longint kx, ky;
            if (count < MAX_POINTS) begin
                px[count] = x;
                py[count] = y;
                count++;
            end
            if (!fin) return;
            n = count;
            count = 0;
            if (n == 0) return;
            pvx = px[0];
            pvy = py[0];
            for (i = 1; i < n; i++) begin
                if (px[i] < pvx || (px[i] == pvx && py[i] < pvy)) begin
                    pvx = px[i];
                    pvy = py[i];
                end
            end
            for (i = 1; i < n; i++) begin
                kx = px[i];
                ky = py[i];
                j = i;
                while (j > 0 && angle_before(kx, ky, px[j-1], py[j-1])) begin
                    px[j] = px[j-1];
                    py[j] = py[j-1];
                    j--;
                end
                px[j] = kx;
                py[j] = ky;
            end
            if (n < 3) begin
                for (i = 0; i < n; i++) push_vertex(i, i + 1 == n);
                return;
            end
            stk[0] = 0;
            stk[1] = 1;
            depth = 2;
            for (i = 2; i < n; i++) begin
                while (depth >= 2 && !(cross3(px[stk[depth-2]], py[stk[depth-2]],
                                              px[stk[depth-1]], py[stk[depth-1]],
                                              px[i], py[i]) > 0))
                    depth--;
                if (depth < MAX_POINTS) begin
                    stk[depth] = i;
                    depth++;
                end
            end
            for (i = 0; i < depth; i++) push_vertex(stk[i] % MAX_POINTS, i + 1 == depth);
        endfunction

        function void check_vertex(coord_t x, coord_t y, logic last);
            vertex_t e;
            if (hull_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected vertex x=%0d y=%0d last=%0b", x, y, last);
                return;
            end
            e = hull_q.pop_front();
            if (e.x !== x || e.y !== y || e.last !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"vertex mismatch: expected x=%0d y=%0d last=%0b, ",
                              "got x=%0d y=%0d last=%0b"},
                             e.x, e.y, e.last, x, y, last);
            end
        endfunction

        function int pending();
            return hull_q.size();
        endfunction
    endclass

    logic          aclk;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    logic signed [15:0] s_pt_x;
    logic signed [15:0] s_pt_y;
    logic          s_final_point;
    logic          m_valid;
    logic          m_ready;
    logic signed [15:0] m_hull_x;
    logic signed [15:0] m_hull_y;
    logic          m_last_vertex;

    hull_scoreboard sb;
    int idle_cycles;
    int items_sent;
    int burst_left;

    convex_hull_graham_scan_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pt_x(s_pt_x), .s_pt_y(s_pt_y), .s_final_point(s_final_point),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_hull_x(m_hull_x), .m_hull_y(m_hull_y), .m_last_vertex(m_last_vertex)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Receiver stall pattern: windows of random length with a random stalled prefix.
    int rx_phase, rx_period, rx_stall;
    initial begin
        rx_phase = 0;
        rx_period = 8;
        rx_stall = 0;
        m_ready = 1'b0;
    end
    always @(negedge aclk) begin
        rx_phase = rx_phase + 1;
        if (rx_phase >= rx_period) begin
            rx_phase = 0;
            rx_period = $urandom_range(1, 16);
            rx_stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, rx_period);
        end
        m_ready <= (rx_phase >= rx_stall);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_vertex(m_hull_x, m_hull_y, m_last_vertex);
    end

    // Watchdog on cycles with no transaction on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Drives one point; returns at the falling edge after it is accepted.
    task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic fin);
        int gap;
        if (burst_left == 0) begin
            s_valid = 1'b0;
            gap = $urandom_range(0, 6);
            repeat (gap) @(negedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_valid = 1'b1;
        s_pt_x = x;
        s_pt_y = y;
        s_final_point = fin;
        do @(posedge aclk); while (!s_ready);
        sb.note_point(x, y, fin);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_random_set(input int n, input bit narrow);
        int i;
        logic signed [15:0] x, y;
        for (i = 0; i < n; i++) begin
            if (narrow) begin
                x = 16'($signed($urandom_range(0, 20)) - 10);
                y = 16'($signed($urandom_range(0, 20)) - 10);
            end else begin
                x = 16'($urandom);
                y = 16'($urandom);
            end
            send_point(x, y, i == n - 1);
        end
    endtask

    initial begin
        int n;
        sb = new();
        idle_cycles = 0;
        items_sent = 0;
        burst_left = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_pt_x = '0;
        s_pt_y = '0;
        s_final_point = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // Single point at the coordinate extremes.
        send_point(-16'sd32768, 16'sd32767, 1'b1);
        // Two points.
        send_point(16'sd32767, -16'sd32768, 1'b0);
        send_point(-16'sd32768, -16'sd32768, 1'b1);
        // All collinear, out of order, with a duplicate.
        send_point(16'sd4, 16'sd4, 1'b0);
        send_point(16'sd1, 16'sd1, 1'b0);
        send_point(16'sd3, 16'sd3, 1'b0);
        send_point(16'sd1, 16'sd1, 1'b1);
        // Full-range square with interior, edge and duplicate points; tied leftmost x.
        send_point(16'sd32767, 16'sd32767, 1'b0);
        send_point(-16'sd32768, 16'sd32767, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(-16'sd32768, -16'sd32768, 1'b0);
        send_point(-16'sd32768, 16'sd0, 1'b0);
        send_point(16'sd32767, -16'sd32768, 1'b0);
        send_point(16'sd0, 16'sd32767, 1'b0);
        send_point(16'sd32767, 16'sd32767, 1'b1);
        // Triangle with a collinear point on the closing edge.
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd10, 16'sd0, 1'b0);
        send_point(16'sd0, 16'sd10, 1'b0);
        send_point(16'sd0, 16'sd5, 1'b1);

        // Overflowing set: the last two points are dropped and the final flag rides on one.
        send_random_set(MAX_POINTS + 2, 1'b0);

        // Hold off until this hull has been fully delivered.
        s_valid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);

        while (items_sent < 180) begin
            if ($urandom_range(0, 9) == 0) begin
                // Hold off until the previous hull has been fully delivered.
                s_valid = 1'b0;
                while (sb.pending() != 0) @(negedge aclk);
            end
            case ($urandom_range(0, 9))
                0:       n = $urandom_range(1, 2);
                1:       n = $urandom_range(11, 24);
                default: n = $urandom_range(3, 10);
            endcase
            send_random_set(n, 1'($urandom_range(0, 1)));
        end
        s_valid = 1'b0;

        while (sb.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
